@@ rtl/brkl_pkg.sv @@
`timescale 1ns / 1ps

package brkl_pkg;

    localparam int unsigned KERNEL_DEPTH_DEF = 32768;

    // action codes of an input item
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_BUS   = 2'd2;
    localparam logic [1:0] ACT_STORE = 2'd3;

    // boot phase codes as seen on the result
    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_HOLD = 2'd1;
    localparam logic [1:0] PHASE_BOOT = 2'd2;
    localparam logic [1:0] PHASE_LOAD = 2'd3;

    // ROM window map
    localparam logic [7:0] ADDR_LOADER_LAST = 8'h20;
    localparam logic [7:0] ADDR_STATUS      = 8'h80;
    localparam logic [7:0] ADDR_DATA        = 8'h81;
    localparam logic [7:0] ADDR_VEC_LO      = 8'hFC;
    localparam logic [7:0] ADDR_VEC_HI      = 8'hFD;
    localparam logic [7:0] NOP_BYTE         = 8'hEA;
    localparam logic [7:0] VEC_LO_BYTE      = 8'h00;
    localparam logic [7:0] VEC_HI_BYTE      = 8'hE0;

    // register indexes (byte address = 4 * index)
    localparam logic REG_KERNEL_SIZE = 1'b0;
    localparam logic REG_HOLD_TICKS  = 1'b1;

    localparam logic [15:0] KERNEL_SIZE_RST = 16'd0;
    localparam logic [7:0]  HOLD_TICKS_RST  = 8'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  bus_address;
        logic        rom_select;
        logic        output_enable;
        logic        write_enable;
        logic [14:0] store_index;
        logic [7:0]  store_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       drive_bus;
        logic       bank_line;
        logic       cpu_reset;
        logic       busy_res;
        logic [1:0] phase;
    } t_out_item;

    // loader program in the low part of the window, NOP padding up to the status register
    function automatic logic [7:0] loader_byte(input logic [7:0] addr);
        logic [7:0] b;
        unique case (addr)
            8'h00: b = 8'h78;  8'h01: b = 8'hD8;
            8'h02: b = 8'hA9;  8'h03: b = 8'h00;  8'h04: b = 8'h85;  8'h05: b = 8'h00;
            8'h06: b = 8'hA9;  8'h07: b = 8'h40;  8'h08: b = 8'h85;  8'h09: b = 8'h01;
            8'h0A: b = 8'hA0;  8'h0B: b = 8'h00;
            8'h0C: b = 8'hAD;  8'h0D: b = 8'h80;  8'h0E: b = 8'hE0;  8'h0F: b = 8'hF0;
            8'h10: b = 8'h0D;
            8'h11: b = 8'hAD;  8'h12: b = 8'h81;  8'h13: b = 8'hE0;  8'h14: b = 8'h91;
            8'h15: b = 8'h00;
            8'h16: b = 8'hC8;  8'h17: b = 8'hD0;  8'h18: b = 8'hF3;
            8'h19: b = 8'hE6;  8'h1A: b = 8'h01;  8'h1B: b = 8'h4C;  8'h1C: b = 8'h0C;
            8'h1D: b = 8'hE0;
            8'h1E: b = 8'h4C;  8'h1F: b = 8'h00;  8'h20: b = 8'h40;
            default: b = NOP_BYTE;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/brkl_store.sv @@
`timescale 1ns / 1ps

module brkl_store #(
    parameter int unsigned DEPTH = 32768,
    parameter int unsigned AW    = 15
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/boot_rom_kernel_loader.sv @@
`timescale 1ns / 1ps

// Boot ROM emulator with kernel loader. Each input item is a clock tick, a boot start,
// a bus cycle or a kernel store write, and gives exactly one result item with the
// data latch, bus drive, bank line, CPU reset, busy flag and phase after that item.
// A start puts the CPU in reset for reset_hold_ticks ticks, then the ROM banks in and
// answers reads: a 33-byte loader (NOP filled up to 0x7F), reset vector $E000 at
// 0xFC/0xFD, status at 0x80 (advances the kernel pointer once per data read, answers
// 1 while bytes remain) and data at 0x81. Reading loader byte 0x20 ends the boot.
// Rate: one item per clock while results are taken; each item passes through stage 1 and
// the result register, and up to two items are held before the input stalls.
// The latency comes from the kernel store, a synchronous RAM with separate write and read
// ports whose registered read data joins the result one stage after the item is taken; all
// control state is updated at the accept edge, so items follow each other freely.
// The store powers up undefined; fill it with store-write items before the boot.
// Registers (APB, byte address 4*i): 0 kernel_size[15:0], 1 reset_hold_ticks[7:0].

module boot_rom_kernel_loader
    import brkl_pkg::t_in_item;
    import brkl_pkg::t_out_item;
#(
    parameter int unsigned KERNEL_DEPTH = brkl_pkg::KERNEL_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import brkl_pkg::*;

    localparam int unsigned AW = $clog2(KERNEL_DEPTH);
    localparam logic [16:0] DEPTH17 = 17'(KERNEL_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = PHASE_IDLE,
        ST_HOLD = PHASE_HOLD,
        ST_BOOT = PHASE_BOOT,
        ST_LOAD = PHASE_LOAD
    } t_phase_e;

    // what stage 1 needs to finish an item once the store data is back
    typedef struct packed {
        logic       latch_en;
        logic       use_mem;
        logic [7:0] latch_val;
        logic       drive_bus;
        logic       bank_line;
        t_phase_e   phase;
    } t_s1;

    // configuration registers
    logic [15:0] r_ksize;
    logic [7:0]  r_hold_ticks;

    // control state
    t_phase_e    r_phase,   n_phase;
    logic [7:0]  r_hold,    n_hold;
    logic [15:0] r_ptr,     n_ptr;
    logic        r_held,    n_held;
    logic        r_bus,     n_bus;
    logic        r_bank,    n_bank;

    // pipeline
    logic        r_s1_vld;
    t_s1         r_s1,      n_s1;
    logic [7:0]  r_latch;
    logic        r_out_vld;
    t_out_item   r_out;

    logic        in_acc;
    logic        s1_adv;
    logic        mem_we;
    logic        mem_re;
    logic [7:0]  mem_rdata;
    logic [7:0]  hold_inc;
    logic [15:0] ptr_inc;
    logic [15:0] widx;
    logic [7:0]  rd_byte;
    logic        active;

    assign s1_adv     = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // ---------------------------------------------------------------- configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HOLD_TICKS) ? {24'd0, r_hold_ticks} : {16'd0, r_ksize};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksize      <= KERNEL_SIZE_RST;
            r_hold_ticks <= HOLD_TICKS_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_KERNEL_SIZE) begin
                r_ksize <= pwdata[15:0];
            end else begin
                r_hold_ticks <= pwdata[7:0];
            end
        end
    end

    // ---------------------------------------------------------------- stage 0: decode
    assign hold_inc = (r_hold == 8'hFF) ? r_hold : r_hold + 8'd1;
    assign ptr_inc  = r_held ? r_ptr : r_ptr + 16'd1;
    assign widx     = {1'b0, i_in_item.store_index};
    assign active   = (r_phase == ST_BOOT) || (r_phase == ST_LOAD);

    always_comb begin
        n_phase = r_phase;
        n_hold  = r_hold;
        n_ptr   = r_ptr;
        n_held  = r_held;
        n_bus   = r_bus;
        n_bank  = r_bank;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        rd_byte = NOP_BYTE;
        n_s1    = '0;

        unique case (i_in_item.action)
            ACT_TICK: begin
                if (r_phase == ST_HOLD) begin
                    n_hold = hold_inc;
                    if (hold_inc >= r_hold_ticks) begin
                        n_phase = ST_BOOT;
                        n_bank  = 1'b0;
                    end
                end
            end
            ACT_START: begin
                if (r_phase == ST_IDLE) begin
                    n_phase = ST_HOLD;
                    n_hold  = 8'd0;
                end
            end
            ACT_BUS: begin
                if (active && i_in_item.rom_select) begin
                    if (i_in_item.output_enable && !i_in_item.write_enable) begin
                        n_s1.latch_en = 1'b1;
                        n_bus         = 1'b1;
                        priority if (i_in_item.bus_address == ADDR_VEC_LO) begin
                            rd_byte = VEC_LO_BYTE;
                        end else if (i_in_item.bus_address == ADDR_VEC_HI) begin
                            rd_byte = VEC_HI_BYTE;
                        end else if (i_in_item.bus_address < ADDR_STATUS) begin
                            rd_byte = loader_byte(i_in_item.bus_address);
                        end else if (i_in_item.bus_address == ADDR_STATUS) begin
                            // pointer moves once per data read
                            n_phase = ST_LOAD;
                            n_held  = 1'b1;
                            n_ptr   = ptr_inc;
                            rd_byte = (ptr_inc < r_ksize) ? 8'd1 : 8'd0;
                        end else if (i_in_item.bus_address == ADDR_DATA) begin
                            rd_byte = 8'd0;
                            if (r_ptr < r_ksize) begin
                                n_held = 1'b0;
                                if ({1'b0, r_ptr} < DEPTH17) begin
                                    mem_re         = 1'b1;
                                    n_s1.use_mem   = 1'b1;
                                end
                            end
                        end else begin
                            rd_byte = NOP_BYTE;
                        end
                        // last loader byte: boot done, bank out
                        if (i_in_item.bus_address == ADDR_LOADER_LAST) begin
                            n_phase = ST_IDLE;
                            n_bank  = 1'b1;
                        end
                    end
                end else if (active) begin
                    n_bus = 1'b0;
                end
            end
            ACT_STORE: begin
                mem_we = ({1'b0, widx} < DEPTH17);
            end
            default: begin
            end
        endcase

        n_s1.latch_val = rd_byte;
        n_s1.drive_bus = n_bus;
        n_s1.bank_line = n_bank;
        n_s1.phase     = n_phase;
    end

    // control state and pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ST_IDLE;
            r_hold    <= 8'd0;
            r_ptr     <= 16'hFFFF;
            r_held    <= 1'b0;
            r_bus     <= 1'b0;
            r_bank    <= 1'b1;
            r_latch   <= 8'd0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase <= n_phase;
                r_hold  <= n_hold;
                r_ptr   <= n_ptr;
                r_held  <= n_held;
                r_bus   <= n_bus;
                r_bank  <= n_bank;
            end
            if (s1_adv) begin
                r_s1_vld  <= in_acc;
                r_out_vld <= r_s1_vld;
                if (r_s1_vld && r_s1.latch_en) begin
                    r_latch <= r_s1.use_mem ? mem_rdata : r_s1.latch_val;
                end
            end else if (in_acc) begin
                // stage 1 was empty behind a stalled result: it takes the item and waits
                r_s1_vld <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv && r_s1_vld) begin
            if (r_s1.latch_en) begin
                r_out.read_data <= r_s1.use_mem ? mem_rdata : r_s1.latch_val;
            end else begin
                r_out.read_data <= r_latch;
            end
            r_out.drive_bus <= r_s1.drive_bus;
            r_out.bank_line <= r_s1.bank_line;
            r_out.cpu_reset <= (r_s1.phase == ST_HOLD);
            r_out.busy_res  <= (r_s1.phase != ST_IDLE);
            r_out.phase     <= r_s1.phase;
        end
    end

    // ---------------------------------------------------------------- kernel store
    brkl_store #(
        .DEPTH (KERNEL_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && mem_we),
        .i_waddr (widx[AW-1:0]),
        .i_wdata (i_in_item.store_byte),
        .i_re    (in_acc && mem_re),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

@@ rtl/brkl_checker.sv @@
`timescale 1ns / 1ps

module brkl_checker
    import brkl_pkg::t_in_item;
    import brkl_pkg::t_out_item;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input t_in_item    i_in_item,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out_item   o_out_item,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    import brkl_pkg::*;

    // CPU reset only in reset hold, busy whenever not idle
    a_reset_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.cpu_reset == (o_out_item.phase == PHASE_HOLD)) &&
                        (o_out_item.busy_res == (o_out_item.phase != PHASE_IDLE)))
        else $error("cpu_reset/busy_res disagree with phase");

    // ROM banked in exactly while booting or loading
    a_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.bank_line ==
            !((o_out_item.phase == PHASE_BOOT) || (o_out_item.phase == PHASE_LOAD))))
        else $error("bank_line disagrees with phase");

    // nothing comes out of an empty pipe after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

endmodule

bind boot_rom_kernel_loader brkl_checker u_brkl_checker (.*);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import brkl_pkg::*;

    // loader program image, 0x00..0x20 of the window
    localparam logic [7:0] LOADER_PROG [0:32] = '{
        8'h78, 8'hD8, 8'hA9, 8'h00, 8'h85, 8'h00, 8'hA9, 8'h40, 8'h85, 8'h01, 8'hA0,
        8'h00, 8'hAD, 8'h80, 8'hE0, 8'hF0, 8'h0D, 8'hAD, 8'h81, 8'hE0, 8'h91, 8'h00,
        8'hC8, 8'hD0, 8'hF3, 8'hE6, 8'h01, 8'h4C, 8'h0C, 8'hE0, 8'h4C, 8'h00, 8'h40
    };
    localparam int DIR_ROWS   = 25;
    localparam int ITEM_GOAL  = 1750;
    localparam int PHASE_SIZE = 250;

    typedef struct packed {
        t_in_item  it;
        logic      typed;   // 1: want holds a hand-written expectation
        t_out_item want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    boot_rom_kernel_loader dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ---------------------------------------------------------------
    // Shadow of the boot ROM: config, control state and kernel store
    // ---------------------------------------------------------------
    logic [15:0] cfg_ksize;
    logic [7:0]  cfg_hold;
    logic [1:0]  boot_ph;
    logic [7:0]  hold_cnt;
    logic [15:0] kptr;
    logic        ptr_held;
    logic        bus_drv;
    logic [7:0]  data_lat;
    logic        bank_lvl;
    logic [7:0]  kstore [0:KERNEL_DEPTH_DEF-1];
    bit          kwritten [0:KERNEL_DEPTH_DEF-1];

    t_out_item   bus_view_q [$];    // expected result items, oldest first
    int          send_pct;          // chance per cycle the sender sits idle
    int          stall_pct;         // chance per cycle the receiver stalls
    int          n_items;
    int          n_boots;
    int          n_kbytes;
    int          n_phases;
    int          n_fail;

    // Applies one item to the shadow state and returns the bus view after it.
    function automatic t_out_item rom_step(input t_in_item it);
        t_out_item r;
        logic      active;
        active = (boot_ph == PHASE_BOOT) || (boot_ph == PHASE_LOAD);
        case (it.action)
            ACT_TICK: begin
                if (boot_ph == PHASE_HOLD) begin
                    if (hold_cnt != 8'hFF)
                        hold_cnt = hold_cnt + 8'd1;
                    if (hold_cnt >= cfg_hold) begin
                        bank_lvl = 1'b0;
                        boot_ph  = PHASE_BOOT;
                    end
                end
            end
            ACT_START: begin
                if (boot_ph == PHASE_IDLE) begin
                    boot_ph  = PHASE_HOLD;
                    hold_cnt = 8'd0;
                    n_boots++;
                end
            end
            ACT_BUS: begin
                if (active && it.rom_select) begin
                    if (it.output_enable && !it.write_enable) begin
                        if (it.bus_address == ADDR_VEC_LO) begin
                            data_lat = VEC_LO_BYTE;
                        end else if (it.bus_address == ADDR_VEC_HI) begin
                            data_lat = VEC_HI_BYTE;
                        end else if (it.bus_address < ADDR_STATUS) begin
                            data_lat = (it.bus_address <= ADDR_LOADER_LAST) ?
                                       LOADER_PROG[it.bus_address] : NOP_BYTE;
                        end else if (it.bus_address == ADDR_STATUS) begin
                            // pointer moves once per consumed data byte
                            boot_ph = PHASE_LOAD;
                            if (!ptr_held) begin
                                ptr_held = 1'b1;
                                kptr     = kptr + 16'd1;
                            end
                            data_lat = (kptr < cfg_ksize) ? 8'd1 : 8'd0;
                        end else if (it.bus_address == ADDR_DATA) begin
                            if (kptr < cfg_ksize) begin
                                ptr_held = 1'b0;
                                n_kbytes++;
                                data_lat = (kptr < KERNEL_DEPTH_DEF) ?
                                           kstore[kptr[14:0]] : 8'd0;
                            end else begin
                                data_lat = 8'd0;
                            end
                        end else begin
                            data_lat = NOP_BYTE;
                        end
                        bus_drv = 1'b1;
                        if (it.bus_address == ADDR_LOADER_LAST) begin
                            boot_ph  = PHASE_IDLE;
                            bank_lvl = 1'b1;
                        end
                    end
                end else if (active) begin
                    bus_drv = 1'b0;
                end
            end
            default: begin
                kstore[it.store_index]   = it.store_byte;
                kwritten[it.store_index] = 1'b1;
            end
        endcase
        r.read_data = data_lat;
        r.drive_bus = bus_drv;
        r.bank_line = bank_lvl;
        r.cpu_reset = (boot_ph == PHASE_HOLD);
        r.busy_res  = (boot_ph != PHASE_IDLE);
        r.phase     = boot_ph;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Item builders; unused fields always carry random bits
    // ---------------------------------------------------------------
    function automatic t_in_item rand_item();
        t_in_item it;
        it = t_in_item'({$urandom, $urandom});
        return it;
    endfunction

    function automatic t_in_item act_item(input logic [1:0] act);
        t_in_item it;
        it = rand_item();
        it.action = act;
        return it;
    endfunction

    function automatic t_in_item bus_item(input logic [7:0] addr, input logic sel,
                                          input logic oe, input logic we);
        t_in_item it;
        it = act_item(ACT_BUS);
        it.bus_address   = addr;
        it.rom_select    = sel;
        it.output_enable = oe;
        it.write_enable  = we;
        return it;
    endfunction

    function automatic t_in_item rd(input logic [7:0] addr);
        return bus_item(addr, 1'b1, 1'b1, 1'b0);
    endfunction

    function automatic t_in_item store_item(input logic [14:0] idx, input logic [7:0] data);
        t_in_item it;
        it = act_item(ACT_STORE);
        it.store_index = idx;
        it.store_byte  = data;
        return it;
    endfunction

    function automatic t_out_item view(input logic [7:0] data, input logic drv,
                                       input logic bank, input logic [1:0] ph);
        t_out_item r;
        r.read_data = data;
        r.drive_bus = drv;
        r.bank_line = bank;
        r.cpu_reset = (ph == PHASE_HOLD);
        r.busy_res  = (ph != PHASE_IDLE);
        r.phase     = ph;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Input channel driver
    // ---------------------------------------------------------------
    // Holds valid until the item is taken, then records its expectation.
    task automatic push_item(input t_in_item it);
        while ($urandom_range(99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        bus_view_q.push_back(rom_step(it));
        n_items++;
    endtask

    // A data read of a never-written store entry is not allowed: fill it first.
    task automatic send_item(input t_in_item it);
        if (it.action == ACT_BUS && it.rom_select && it.output_enable &&
            !it.write_enable && it.bus_address == ADDR_DATA &&
            (boot_ph == PHASE_BOOT || boot_ph == PHASE_LOAD) &&
            kptr < cfg_ksize && kptr < KERNEL_DEPTH_DEF && !kwritten[kptr[14:0]])
            push_item(store_item(kptr[14:0], 8'($urandom_range(255))));
        push_item(it);
    endtask

    // Drop valid and wait until every expected result came back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (bus_view_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write, then read back; only called with the item channel quiet.
    task automatic write_reg(input logic idx, input logic [31:0] val);
        logic [31:0] want;
        want = (idx == REG_KERNEL_SIZE) ? {16'd0, val[15:0]} : {24'd0, val[7:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("register %0d: expected %0h, got %0h", idx, want, prdata);
            n_fail++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_KERNEL_SIZE)
            cfg_ksize = val[15:0];
        else
            cfg_hold = val[7:0];
        @(posedge i_clk);
    endtask

    // One boot: start, reset hold, a random loader session, closing read, trailing random items.
    task automatic run_boot();
        t_in_item it;
        int       r;
        logic     oe;
        send_item(act_item(ACT_START));
        while (boot_ph == PHASE_HOLD) begin
            r = $urandom_range(99);
            if (r < 80)
                send_item(act_item(ACT_TICK));
            else if (r < 90)
                send_item(bus_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                                   1'($urandom_range(1)), 1'($urandom_range(1))));
            else
                send_item(rand_item());
        end
        repeat ($urandom_range(4, 40)) begin
            r = $urandom_range(99);
            if (r < 35) begin
                // loader poll loop: status, then data while bytes remain and now and then beyond
                send_item(rd(ADDR_STATUS));
                if (data_lat == 8'd1 || $urandom_range(3) == 0)
                    send_item(rd(ADDR_DATA));
            end else if (r < 55) begin
                it = rd($urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom_range(255)));
                if (it.bus_address == ADDR_LOADER_LAST)
                    it.bus_address = 8'h1F;
                send_item(it);
            end else if (r < 65) begin
                send_item(bus_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)),
                                   1'($urandom_range(1))));
            end else if (r < 75) begin
                // selected but not a read
                oe = 1'($urandom_range(1));
                send_item(bus_item(8'($urandom_range(255)), 1'b1, oe,
                                   oe ? 1'b1 : 1'($urandom_range(1))));
            end else if (r < 85) begin
                send_item(rand_item());
            end else begin
                send_item(store_item(15'($urandom_range(32767)), 8'($urandom_range(255))));
            end
        end
        send_item(rd(ADDR_LOADER_LAST));
        repeat ($urandom_range(3))
            send_item(rand_item());
    endtask

    // ---------------------------------------------------------------
    // Clock, receiver stall, timeout
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < stall_pct);

    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Result checker: every taken result against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (bus_view_q.size() == 0) begin
                $error("result item with nothing expected");
                n_fail++;
            end else begin
                want = bus_view_q.pop_front();
                if (o_out_item.read_data !== want.read_data) begin
                    $error("read_data: expected %0h, got %0h",
                           want.read_data, o_out_item.read_data);
                    n_fail++;
                end
                if (o_out_item.drive_bus !== want.drive_bus) begin
                    $error("drive_bus: expected %0b, got %0b",
                           want.drive_bus, o_out_item.drive_bus);
                    n_fail++;
                end
                if (o_out_item.bank_line !== want.bank_line) begin
                    $error("bank_line: expected %0b, got %0b",
                           want.bank_line, o_out_item.bank_line);
                    n_fail++;
                end
                if (o_out_item.cpu_reset !== want.cpu_reset) begin
                    $error("cpu_reset: expected %0b, got %0b",
                           want.cpu_reset, o_out_item.cpu_reset);
                    n_fail++;
                end
                if (o_out_item.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0b, got %0b",
                           want.busy_res, o_out_item.busy_res);
                    n_fail++;
                end
                if (o_out_item.phase !== want.phase) begin
                    $error("phase: expected %0d, got %0d", want.phase, o_out_item.phase);
                    n_fail++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : main_seq
        t_dir_row dir_rows [DIR_ROWS];
        int       p;
        int       target;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_out_stall <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        send_pct    = 0;
        stall_pct   = 0;
        n_items     = 0;
        n_boots     = 0;
        n_kbytes    = 0;
        n_phases    = 0;
        n_fail      = 0;

        // shadow reset state
        cfg_ksize = KERNEL_SIZE_RST;
        cfg_hold  = HOLD_TICKS_RST;
        boot_ph   = PHASE_IDLE;
        hold_cnt  = 8'd0;
        kptr      = 16'hFFFF;
        ptr_held  = 1'b0;
        bus_drv   = 1'b0;
        data_lat  = 8'd0;
        bank_lvl  = 1'b1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk at reset config (size 0, hold 5): ignored items while
        // idle and in hold, release on the fifth tick, vector and NOP reads,
        // deselect, write cycle, status/data with no kernel, end of boot.
        dir_rows[0]  = '{act_item(ACT_TICK),  1'b1, view(8'h00, 1'b0, 1'b1, PHASE_IDLE)};
        dir_rows[1]  = '{rd(8'h00),           1'b1, view(8'h00, 1'b0, 1'b1, PHASE_IDLE)};
        dir_rows[2]  = '{store_item(15'h0000, 8'hFF), 1'b0, '0};
        dir_rows[3]  = '{store_item(15'h7FFF, 8'h00), 1'b0, '0};
        dir_rows[4]  = '{act_item(ACT_START), 1'b1, view(8'h00, 1'b0, 1'b1, PHASE_HOLD)};
        dir_rows[5]  = '{act_item(ACT_START), 1'b1, view(8'h00, 1'b0, 1'b1, PHASE_HOLD)};
        dir_rows[6]  = '{rd(8'h00),           1'b1, view(8'h00, 1'b0, 1'b1, PHASE_HOLD)};
        dir_rows[7]  = '{act_item(ACT_TICK),  1'b1, view(8'h00, 1'b0, 1'b1, PHASE_HOLD)};
        dir_rows[8]  = '{act_item(ACT_TICK),  1'b1, view(8'h00, 1'b0, 1'b1, PHASE_HOLD)};
        dir_rows[9]  = '{act_item(ACT_TICK),  1'b1, view(8'h00, 1'b0, 1'b1, PHASE_HOLD)};
        dir_rows[10] = '{act_item(ACT_TICK),  1'b1, view(8'h00, 1'b0, 1'b1, PHASE_HOLD)};
        dir_rows[11] = '{act_item(ACT_TICK),  1'b1, view(8'h00, 1'b0, 1'b0, PHASE_BOOT)};
        dir_rows[12] = '{rd(8'h00),           1'b1, view(8'h78, 1'b1, 1'b0, PHASE_BOOT)};
        dir_rows[13] = '{rd(ADDR_VEC_LO),     1'b1, view(8'h00, 1'b1, 1'b0, PHASE_BOOT)};
        dir_rows[14] = '{rd(ADDR_VEC_HI),     1'b1, view(8'hE0, 1'b1, 1'b0, PHASE_BOOT)};
        dir_rows[15] = '{rd(8'h7F),           1'b1, view(8'hEA, 1'b1, 1'b0, PHASE_BOOT)};
        dir_rows[16] = '{rd(8'hFF),           1'b1, view(8'hEA, 1'b1, 1'b0, PHASE_BOOT)};
        dir_rows[17] = '{bus_item(8'h00, 1'b0, 1'b1, 1'b0), 1'b1,
                         view(8'hEA, 1'b0, 1'b0, PHASE_BOOT)};
        dir_rows[18] = '{bus_item(8'h00, 1'b1, 1'b1, 1'b1), 1'b0, '0};
        dir_rows[19] = '{rd(ADDR_STATUS),     1'b1, view(8'h00, 1'b1, 1'b0, PHASE_LOAD)};
        dir_rows[20] = '{rd(ADDR_DATA),       1'b1, view(8'h00, 1'b1, 1'b0, PHASE_LOAD)};
        dir_rows[21] = '{rd(ADDR_STATUS),     1'b0, '0};
        dir_rows[22] = '{act_item(ACT_TICK),  1'b0, '0};
        dir_rows[23] = '{rd(ADDR_LOADER_LAST), 1'b1, view(8'h40, 1'b1, 1'b1, PHASE_IDLE)};
        dir_rows[24] = '{bus_item(8'h00, 1'b0, 1'b1, 1'b0), 1'b1,
                         view(8'h40, 1'b1, 1'b1, PHASE_IDLE)};

        for (int k = 0; k < DIR_ROWS; k++) begin
            send_item(dir_rows[k].it);
            // hand-written value replaces the prediction; its result is not out yet
            if (dir_rows[k].typed)
                bus_view_q[$] = dir_rows[k].want;
        end
        drain();

        // Random phases: each one a config setting and an idling pattern.
        p = 0;
        while (n_items < ITEM_GOAL) begin
            case (p % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 71; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 71; end
                default: begin send_pct = 17; stall_pct = 17; end
            endcase
            case (p % 6)
                0: begin write_reg(REG_KERNEL_SIZE, 32'd32768); write_reg(REG_HOLD_TICKS, 32'd1);   end
                1: begin write_reg(REG_KERNEL_SIZE, 32'd1);     write_reg(REG_HOLD_TICKS, 32'd255); end
                2: begin write_reg(REG_KERNEL_SIZE, 32'd0);     write_reg(REG_HOLD_TICKS, 32'd0);   end
                3: begin
                    write_reg(REG_KERNEL_SIZE, $urandom_range(32768));
                    write_reg(REG_HOLD_TICKS, $urandom_range(1, 12));
                end
                4: begin
                    write_reg(REG_KERNEL_SIZE, $urandom_range(600));
                    write_reg(REG_HOLD_TICKS, 32'd2);
                end
                default: begin
                    write_reg(REG_KERNEL_SIZE, 32'h7FFF);
                    write_reg(REG_HOLD_TICKS, $urandom_range(1, 255));
                end
            endcase
            target = n_items + PHASE_SIZE;
            while (n_items < target)
                run_boot();
            drain();
            n_phases++;
            p++;
        end

        $display("covered %0d items in %0d boots over %0d config phases", n_items, n_boots,
                 n_phases);
        $display("%0d kernel bytes fetched, kernel pointer ended at %0h", n_kbytes, kptr);
        if (n_fail == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

@@ boot_rom_kernel_loader.f @@
rtl/brkl_pkg.sv
rtl/brkl_store.sv
rtl/boot_rom_kernel_loader.sv
rtl/brkl_checker.sv
dv/tb.sv
